[sv/ipc_pkg.sv]
// shared types and constants for the inverter protection controller
package ipc_pkg;

  // controller mode, also the encoding seen on the mode output
  typedef enum logic [2:0] {
    MODE_INIT     = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_STARTING = 3'd2,
    MODE_RUNNING  = 3'd3,
    MODE_FAULT    = 3'd4
  } mode_t;

  // latched fault cause, lowest nonzero code wins
  typedef enum logic [2:0] {
    FLT_NONE      = 3'd0,
    FLT_UNDERVOLT = 3'd1,
    FLT_OVERVOLT  = 3'd2,
    FLT_OVERTEMP  = 3'd3,
    FLT_OVERCURR  = 3'd4
  } fault_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 3;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DC_MIN      = 3'd0;
  localparam cfg_idx_t CFG_DC_MAX      = 3'd1;
  localparam cfg_idx_t CFG_TEMP_MAX    = 3'd2;
  localparam cfg_idx_t CFG_CURRENT_MAX = 3'd3;
  localparam cfg_idx_t CFG_FAN_TEMP    = 3'd4;

  // limit values after reset, in raw counts
  localparam int unsigned DC_MIN_RESET      = 2400;
  localparam int unsigned DC_MAX_RESET      = 4000;
  localparam int unsigned TEMP_MAX_RESET    = 800;
  localparam int unsigned CURRENT_MAX_RESET = 1600;
  localparam int unsigned FAN_TEMP_RESET    = 500;

  // per-tick control from the pipeline to the core
  typedef struct packed {
    logic step;
  } core_ctrl_t;

endpackage

[sv/inverter_protection_controller_top.sv]
// top level: input stage, output handshake, config file and protection core
// a beat waits in the input stage, then loads the core registers and out_valid
// throughput: one beat per cycle while out_ready is high, set by the single input stage feeding the core registers
// a waiting result stalls the input stage only when out_ready is low
// reset (rst_n low, synchronous): mode init, outputs cleared except the power product, limits to defaults
module inverter_protection_controller_top #(
  parameter int SAMPLE_BITS = 12,
  parameter int ENERGY_BITS = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // sample channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [SAMPLE_BITS-1:0]       in_dc_voltage_sample,
  input  logic [SAMPLE_BITS-1:0]       in_dc_current_sample,
  input  logic [SAMPLE_BITS-1:0]       in_temperature_sample,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_mode,
  output logic                         out_drive_enable,
  output logic                         out_fan_enable,
  output logic [2:0]                   out_latched_fault,
  output logic                         out_fault_event,
  output logic [SAMPLE_BITS-1:0]       out_fault_sample,
  output logic [31:0]                  out_fault_time,
  output logic [2*SAMPLE_BITS-1:0]     out_power_product,
  output logic [ENERGY_BITS-1:0]       out_energy_total,
  output logic [31:0]                  out_running_ticks,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  ipc_pkg::cfg_idx_t            cfg_index,
  input  logic [SAMPLE_BITS-1:0]       cfg_data
);

  localparam int PROD_BITS = 2 * SAMPLE_BITS;

  // input stage: samples plus their product, taken straight from the ports
  logic                    s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_BITS-1:0]  s1_volt_r, s1_curr_r, s1_temp_r;
  logic [PROD_BITS-1:0]    s1_prod_r;
  logic                    out_valid_r, out_valid_nxt;

  logic                    in_fire;
  logic                    out_free;   // result register can be loaded this cycle
  ipc_pkg::core_ctrl_t     core_ctrl;

  logic [SAMPLE_BITS-1:0]  lim_dc_min, lim_dc_max, lim_temp_max, lim_curr_max, lim_fan_temp;
  ipc_pkg::mode_t          core_mode;
  ipc_pkg::fault_t         core_fault;

  assign out_free       = !out_valid_r || out_ready;
  assign in_ready       = !s1_valid_r || out_free;
  assign in_fire        = in_valid && in_ready;
  assign core_ctrl.step = s1_valid_r && out_free;

  // stage valid bookkeeping
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (out_free) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_free) out_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload of the input stage, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_volt_r <= in_dc_voltage_sample;
      s1_curr_r <= in_dc_current_sample;
      s1_temp_r <= in_temperature_sample;
      s1_prod_r <= PROD_BITS'(in_dc_voltage_sample) * PROD_BITS'(in_dc_current_sample);
    end
  end

  // config writes are always taken
  assign cfg_ready = 1'b1;

  ipc_cfg_regs #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (cfg_valid && cfg_ready),
    .wr_index    (cfg_index),
    .wr_data     (cfg_data),
    .dc_min      (lim_dc_min),
    .dc_max      (lim_dc_max),
    .temp_max    (lim_temp_max),
    .curr_limit  (lim_curr_max),
    .fan_temp    (lim_fan_temp)
  );

  // core state doubles as the result register
  ipc_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ENERGY_BITS (ENERGY_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (core_ctrl),
    .volt          (s1_volt_r),
    .curr          (s1_curr_r),
    .temp          (s1_temp_r),
    .product       (s1_prod_r),
    .dc_min        (lim_dc_min),
    .dc_max        (lim_dc_max),
    .temp_max      (lim_temp_max),
    .curr_limit    (lim_curr_max),
    .fan_temp      (lim_fan_temp),
    .mode          (core_mode),
    .drive_enable  (out_drive_enable),
    .fan_enable    (out_fan_enable),
    .fault_code    (core_fault),
    .fault_event   (out_fault_event),
    .fault_sample  (out_fault_sample),
    .fault_time    (out_fault_time),
    .power_product (out_power_product),
    .energy_total  (out_energy_total),
    .running_ticks (out_running_ticks)
  );

  assign out_valid         = out_valid_r;
  assign out_mode          = core_mode;
  assign out_latched_fault = core_fault;

`ifndef SYNTHESIS
  // a fault event only comes with the fault mode and a recorded cause
  a_event_in_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault_event |->
      core_mode == ipc_pkg::MODE_FAULT && core_fault != ipc_pkg::FLT_NONE)
    else $error("fault event without fault mode or cause");

  // output stage never enabled once in fault
  a_no_drive_in_fault: assert property (@(posedge clk) disable iff (!rst_n)
    core_mode == ipc_pkg::MODE_FAULT |-> !out_drive_enable)
    else $error("drive enabled in fault mode");

  // first fault stays latched until reset
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    core_fault != ipc_pkg::FLT_NONE |=>
      $stable(core_fault) && $stable(out_fault_sample) && $stable(out_fault_time))
    else $error("latched fault changed");

  // core advances only when a stage item moves into the result register
  a_step_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    core_ctrl.step |=> out_valid)
    else $error("core stepped without presenting a result");
`endif

endmodule

[sv/ipc_cfg_regs.sv]
// configuration register file holding the protection limits
module ipc_cfg_regs #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  ipc_pkg::cfg_idx_t            wr_index,
  input  logic [SAMPLE_BITS-1:0]       wr_data,
  output logic [SAMPLE_BITS-1:0]       dc_min,
  output logic [SAMPLE_BITS-1:0]       dc_max,
  output logic [SAMPLE_BITS-1:0]       temp_max,
  output logic [SAMPLE_BITS-1:0]       curr_limit,
  output logic [SAMPLE_BITS-1:0]       fan_temp
);

  localparam logic [SAMPLE_BITS-1:0] DC_MIN_RST =
    SAMPLE_BITS'(ipc_pkg::DC_MIN_RESET);
  localparam logic [SAMPLE_BITS-1:0] DC_MAX_RST =
    SAMPLE_BITS'(ipc_pkg::DC_MAX_RESET);
  localparam logic [SAMPLE_BITS-1:0] TEMP_MAX_RST =
    SAMPLE_BITS'(ipc_pkg::TEMP_MAX_RESET);
  localparam logic [SAMPLE_BITS-1:0] CURRENT_MAX_RST =
    SAMPLE_BITS'(ipc_pkg::CURRENT_MAX_RESET);
  localparam logic [SAMPLE_BITS-1:0] FAN_TEMP_RST =
    SAMPLE_BITS'(ipc_pkg::FAN_TEMP_RESET);

  logic [SAMPLE_BITS-1:0] dc_min_r, dc_max_r, temp_max_r, curr_limit_r, fan_temp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_min_r     <= DC_MIN_RST;
      dc_max_r     <= DC_MAX_RST;
      temp_max_r   <= TEMP_MAX_RST;
      curr_limit_r <= CURRENT_MAX_RST;
      fan_temp_r   <= FAN_TEMP_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        ipc_pkg::CFG_DC_MIN:      dc_min_r     <= wr_data;
        ipc_pkg::CFG_DC_MAX:      dc_max_r     <= wr_data;
        ipc_pkg::CFG_TEMP_MAX:    temp_max_r   <= wr_data;
        ipc_pkg::CFG_CURRENT_MAX: curr_limit_r <= wr_data;
        ipc_pkg::CFG_FAN_TEMP:    fan_temp_r   <= wr_data;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  assign dc_min     = dc_min_r;
  assign dc_max     = dc_max_r;
  assign temp_max   = temp_max_r;
  assign curr_limit = curr_limit_r;
  assign fan_temp   = fan_temp_r;

endmodule

[sv/ipc_core.sv]
// mode sequencer, limit check, fault latch and energy accounting
module ipc_core #(
  parameter int SAMPLE_BITS = 12,
  parameter int ENERGY_BITS = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ipc_pkg::core_ctrl_t          ctrl,
  input  logic [SAMPLE_BITS-1:0]       volt,
  input  logic [SAMPLE_BITS-1:0]       curr,
  input  logic [SAMPLE_BITS-1:0]       temp,
  input  logic [2*SAMPLE_BITS-1:0]     product,
  input  logic [SAMPLE_BITS-1:0]       dc_min,
  input  logic [SAMPLE_BITS-1:0]       dc_max,
  input  logic [SAMPLE_BITS-1:0]       temp_max,
  input  logic [SAMPLE_BITS-1:0]       curr_limit,
  input  logic [SAMPLE_BITS-1:0]       fan_temp,
  output ipc_pkg::mode_t               mode,
  output logic                         drive_enable,
  output logic                         fan_enable,
  output ipc_pkg::fault_t              fault_code,
  output logic                         fault_event,
  output logic [SAMPLE_BITS-1:0]       fault_sample,
  output logic [31:0]                  fault_time,
  output logic [2*SAMPLE_BITS-1:0]     power_product,
  output logic [ENERGY_BITS-1:0]       energy_total,
  output logic [31:0]                  running_ticks
);

  localparam int PROD_BITS = 2 * SAMPLE_BITS;

  ipc_pkg::mode_t          mode_r, mode_nxt;
  logic                    enable_r, enable_nxt;
  logic                    fan_r, fan_nxt;
  ipc_pkg::fault_t         fcode_r, fcode_nxt;
  logic [SAMPLE_BITS-1:0]  fval_r, fval_nxt;
  logic [31:0]             ftick_r, ftick_nxt;
  logic                    event_r, event_nxt;
  logic [31:0]             tick_r;
  logic [ENERGY_BITS-1:0]  energy_r, energy_nxt;
  logic [31:0]             run_r, run_nxt;
  logic [PROD_BITS-1:0]    prod_r;

  ipc_pkg::fault_t         chk_code;
  logic [SAMPLE_BITS-1:0]  chk_val;
  logic [ENERGY_BITS:0]    esum;

  // prioritized strict-limit check
  always_comb begin
    chk_code = ipc_pkg::FLT_NONE;
    chk_val  = '0;
    if (volt < dc_min) begin
      chk_code = ipc_pkg::FLT_UNDERVOLT;
      chk_val  = volt;
    end else if (volt > dc_max) begin
      chk_code = ipc_pkg::FLT_OVERVOLT;
      chk_val  = volt;
    end else if (temp > temp_max) begin
      chk_code = ipc_pkg::FLT_OVERTEMP;
      chk_val  = temp;
    end else if (curr > curr_limit) begin
      chk_code = ipc_pkg::FLT_OVERCURR;
      chk_val  = curr;
    end
  end

  assign esum = {1'b0, energy_r} + (ENERGY_BITS+1)'(product);

  always_comb begin
    mode_nxt   = mode_r;
    enable_nxt = enable_r;
    fan_nxt    = fan_r | (temp > fan_temp);
    fcode_nxt  = fcode_r;
    fval_nxt   = fval_r;
    ftick_nxt  = ftick_r;
    event_nxt  = 1'b0;
    energy_nxt = energy_r;
    run_nxt    = run_r;

    unique case (mode_r) inside
      ipc_pkg::MODE_INIT: begin
        enable_nxt = 1'b0;
        fan_nxt    = 1'b0;
        mode_nxt   = ipc_pkg::MODE_IDLE;
      end
      ipc_pkg::MODE_IDLE: begin
        if (volt > dc_min) mode_nxt = ipc_pkg::MODE_STARTING;
      end
      ipc_pkg::MODE_STARTING, ipc_pkg::MODE_RUNNING: begin
        if (mode_r == ipc_pkg::MODE_STARTING) begin
          fan_nxt    = 1'b1;
          enable_nxt = 1'b1;
        end else begin
          energy_nxt = esum[ENERGY_BITS] ? '1 : esum[ENERGY_BITS-1:0];
          run_nxt    = run_r + 32'd1;
        end
        if (chk_code != ipc_pkg::FLT_NONE) begin
          mode_nxt   = ipc_pkg::MODE_FAULT;
          enable_nxt = 1'b0;
          if (fcode_r == ipc_pkg::FLT_NONE) begin
            fcode_nxt = chk_code;
            fval_nxt  = chk_val;
            ftick_nxt = tick_r;
            event_nxt = 1'b1;
          end
        end else begin
          mode_nxt = ipc_pkg::MODE_RUNNING;
        end
      end
      default: begin
        mode_nxt   = ipc_pkg::MODE_FAULT;
        enable_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ipc_pkg::MODE_INIT;
      enable_r <= 1'b0;
      fan_r    <= 1'b0;
      fcode_r  <= ipc_pkg::FLT_NONE;
      fval_r   <= '0;
      ftick_r  <= '0;
      event_r  <= 1'b0;
      tick_r   <= '0;
      energy_r <= '0;
      run_r    <= '0;
    end else if (ctrl.step) begin
      mode_r   <= mode_nxt;
      enable_r <= enable_nxt;
      fan_r    <= fan_nxt;
      fcode_r  <= fcode_nxt;
      fval_r   <= fval_nxt;
      ftick_r  <= ftick_nxt;
      event_r  <= event_nxt;
      tick_r   <= tick_r + 32'd1;
      energy_r <= energy_nxt;
      run_r    <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) prod_r <= product;
  end

  assign mode          = mode_r;
  assign drive_enable  = enable_r;
  assign fan_enable    = fan_r;
  assign fault_code    = fcode_r;
  assign fault_event   = event_r;
  assign fault_sample  = fval_r;
  assign fault_time    = ftick_r;
  assign power_product = prod_r;
  assign energy_total  = energy_r;
  assign running_ticks = run_r;

endmodule
